### sv/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag model.
// No dependencies; imported by the front, back and top-level modules.
package salc_pkg;

    // Input transaction: access kind and byte address.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
    } access_t;

    // Result transaction: per-access flags and running totals.
    typedef struct packed {
        logic        was_hit;
        logic        was_miss;
        logic        was_evicted;
        logic        extra_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } result_t;

    // Access kinds that change behavior.
    localparam logic [1:0] OP_MODIFY = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_USED      = 2'd2;

    // Configuration reset values.
    localparam logic [3:0] RST_SET_INDEX_BITS = 4'd4;
    localparam logic [4:0] RST_OFFSET_BITS    = 5'd4;
    localparam logic [3:0] RST_WAYS_USED      = 4'd1;

    // Widths of the use clock, line ages and running totals.
    localparam int AGE_W = 32;
    localparam int CNT_W = 32;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

endpackage

### sv/salc_queue.sv
// Small valid/ready FIFO that decouples the classifying front from the back.
// No dependencies.
module salc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign in_ready  = (fill_reg != FILL_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### sv/salc_front.sv
// Front of the cache tag model: configuration registers, input handshake and
// set/tag extraction for each access. Depends on salc_pkg.
module salc_front
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32,
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int WCNT_W = $clog2(MAX_WAYS + 1),
    localparam int REQ_W  = 1 + WCNT_W + ADDR_WIDTH + SET_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  access_t                s_data,
    input  logic                   clear_busy,
    input  logic                   q_in_ready,
    output logic                   q_push,
    output logic [REQ_W-1:0]       q_in_data
);

    logic [3:0]            set_index_bits_reg;
    logic [4:0]            offset_bits_reg;
    logic [3:0]            ways_used_reg;
    logic [3:0]            set_bits;
    logic [ADDR_WIDTH-1:0] addr_w;
    logic [ADDR_WIDTH-1:0] set_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      req_set;
    logic [5:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] req_tag;
    logic [WCNT_W-1:0]     req_ways;
    logic                  req_modify;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_index_bits_reg <= RST_SET_INDEX_BITS;
            offset_bits_reg    <= RST_OFFSET_BITS;
            ways_used_reg      <= RST_WAYS_USED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SET_INDEX_BITS: set_index_bits_reg <= cfg_data[3:0];
                CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data[4:0];
                CFG_WAYS_USED:      ways_used_reg      <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Items are taken when the queue has room and the tag memory is ready.
    assign s_ready = q_in_ready && !clear_busy;
    assign q_push  = s_valid && s_ready;

    // Split the address into set index and tag, and clamp the way count.
    always_comb begin
        set_bits = (set_index_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                           : set_index_bits_reg;
        addr_w      = ADDR_WIDTH'(s_data.address);
        set_shifted = addr_w >> offset_bits_reg;
        set_mask    = ~({SET_W{1'b1}} << set_bits);
        req_set     = set_shifted[SET_W-1:0] & set_mask;
        tag_shift   = 6'(set_bits) + 6'(offset_bits_reg);
        req_tag     = addr_w >> tag_shift;
        if (ways_used_reg == '0) begin
            req_ways = WCNT_W'(1);
        end else if ({1'b0, ways_used_reg} > 5'(MAX_WAYS)) begin
            req_ways = WCNT_W'(MAX_WAYS);
        end else begin
            req_ways = WCNT_W'(ways_used_reg);
        end
        req_modify = (s_data.opcode == OP_MODIFY);
    end

    assign q_in_data = {req_modify, req_ways, req_tag, req_set};

endmodule

### sv/salc_back.sv
// Back of the cache tag model: tag memory with its clearing pass, hit and LRU
// victim selection, running totals and the result register. Depends on salc_pkg.
module salc_back
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32,
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int WCNT_W = $clog2(MAX_WAYS + 1),
    localparam int REQ_W  = 1 + WCNT_W + ADDR_WIDTH + SET_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  logic [REQ_W-1:0] q_data,
    output logic             clear_busy,
    output logic             m_valid,
    input  logic             m_ready,
    output result_t          m_data
);

    localparam int TAG_W   = ADDR_WIDTH;
    localparam int ROWS    = 1 << SET_W;
    localparam int AGE_LSB = MAX_WAYS;
    localparam int TAG_LSB = MAX_WAYS + MAX_WAYS * AGE_W;
    localparam int ROW_W   = TAG_LSB + MAX_WAYS * TAG_W;
    localparam int LV      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LEAVES  = 1 << LV;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    // Tag memory: one row per set holding valid bits, ages and tags of all ways.
    logic [ROW_W-1:0] tag_mem [ROWS];
    logic [ROW_W-1:0] rd_row_reg;

    logic [1:0]        state_reg, state_next;
    logic [SET_W-1:0]  clear_idx_reg, clear_idx_next;
    logic [SET_W-1:0]  req_set_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic [WCNT_W-1:0] req_ways_reg;
    logic              req_modify_reg;
    logic [AGE_W-1:0]  use_clock_reg, use_clock_next;
    logic [CNT_W-1:0]  hits_reg, hits_next;
    logic [CNT_W-1:0]  misses_reg, misses_next;
    logic [CNT_W-1:0]  evicts_reg, evicts_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg;

    logic              mem_re, mem_we;
    logic [SET_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              out_free, do_eval;

    logic [MAX_WAYS-1:0] present, match, free;
    logic [AGE_W-1:0]    age_gap [MAX_WAYS];
    logic                node_ok   [LV+1][LEAVES];
    logic [AGE_W-1:0]    node_dist [LV+1][LEAVES];
    logic [LV-1:0]       node_way  [LV+1][LEAVES];
    logic                hit, have_free, evicted;
    logic [LV-1:0]       hit_way, free_way, target;
    logic [ROW_W-1:0]    new_row;
    logic [1:0]          hits_add;
    logic [CNT_W:0]      hits_sum, misses_sum, evicts_sum;

    assign clear_busy = (state_reg == ST_CLEAR);
    assign out_free   = !m_valid_reg || m_ready;
    assign do_eval    = (state_reg == ST_EVAL) && out_free;
    assign mem_re     = (state_reg == ST_IDLE) && q_valid;
    assign q_pop      = mem_re;

    // Per-way classification of the row that was read.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            present[w] = (WCNT_W'(w) < req_ways_reg) && rd_row_reg[w];
            free[w]    = (WCNT_W'(w) < req_ways_reg) && !rd_row_reg[w];
            match[w]   = present[w]
                         && (rd_row_reg[TAG_LSB + w * TAG_W +: TAG_W] == req_tag_reg);
            age_gap[w] = use_clock_reg - rd_row_reg[AGE_LSB + w * AGE_W +: AGE_W];
        end
    end

    // Lowest matching way and lowest free way.
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = LV'(w);
            end
            if (free[w]) begin
                free_way = LV'(w);
            end
        end
        hit       = |match;
        have_free = |free;
        evicted   = !hit && !have_free;
    end

    // Victim search: a tree of age comparisons; the lower way wins a tie.
    always_comb begin
        for (int l = 0; l <= LV; l++) begin
            for (int i = 0; i < LEAVES; i++) begin
                node_ok[l][i]   = 1'b0;
                node_dist[l][i] = '0;
                node_way[l][i]  = '0;
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            node_ok[0][i]   = present[i];
            node_dist[0][i] = age_gap[i];
            node_way[0][i]  = LV'(i);
        end
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
                if (node_ok[l][2*i+1]
                    && (!node_ok[l][2*i] || node_dist[l][2*i+1] > node_dist[l][2*i])) begin
                    node_ok[l+1][i]   = 1'b1;
                    node_dist[l+1][i] = node_dist[l][2*i+1];
                    node_way[l+1][i]  = node_way[l][2*i+1];
                end else begin
                    node_ok[l+1][i]   = node_ok[l][2*i];
                    node_dist[l+1][i] = node_dist[l][2*i];
                    node_way[l+1][i]  = node_way[l][2*i];
                end
            end
        end
    end

    // Updated row: refresh the hit way, or fill the free or victim way.
    always_comb begin
        if (hit) begin
            target = hit_way;
        end else if (have_free) begin
            target = free_way;
        end else begin
            target = node_way[LV][0];
        end
        new_row = rd_row_reg;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (LV'(w) == target) begin
                new_row[AGE_LSB + w * AGE_W +: AGE_W] = use_clock_reg;
                if (!hit) begin
                    new_row[w] = 1'b1;
                    new_row[TAG_LSB + w * TAG_W +: TAG_W] = req_tag_reg;
                end
            end
        end
    end

    // Saturating totals; a modify may add two hits at once.
    always_comb begin
        hits_add    = {1'b0, hit} + {1'b0, req_modify_reg};
        hits_sum    = {1'b0, hits_reg} + (CNT_W + 1)'(hits_add);
        misses_sum  = {1'b0, misses_reg} + (CNT_W + 1)'(!hit);
        evicts_sum  = {1'b0, evicts_reg} + (CNT_W + 1)'(evicted);
        hits_next   = hits_sum[CNT_W] ? '1 : hits_sum[CNT_W-1:0];
        misses_next = misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
        evicts_next = evicts_sum[CNT_W] ? '1 : evicts_sum[CNT_W-1:0];
        use_clock_next = use_clock_reg + 1'b1;
    end

    // Sequencer: clearing pass, then read a set and evaluate it.
    always_comb begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = req_set_reg;
        mem_wdata      = new_row;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = clear_idx_reg;
                mem_wdata      = '0;
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_idx_reg == SET_W'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    mem_we       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            use_clock_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            m_valid_reg   <= m_valid_next;
            if (do_eval) begin
                use_clock_reg <= use_clock_next;
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evicts_reg    <= evicts_next;
            end
        end
    end

    // Request fields are captured as the queue head is popped.
    always_ff @(posedge aclk) begin
        if (mem_re) begin
            req_set_reg    <= q_data[SET_W-1:0];
            req_tag_reg    <= q_data[SET_W +: TAG_W];
            req_ways_reg   <= q_data[SET_W + TAG_W +: WCNT_W];
            req_modify_reg <= q_data[REQ_W-1];
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (do_eval) begin
            m_data_reg.was_hit     <= hit;
            m_data_reg.was_miss    <= !hit;
            m_data_reg.was_evicted <= evicted;
            m_data_reg.extra_hit   <= req_modify_reg;
            m_data_reg.hit_total   <= hits_next;
            m_data_reg.miss_total  <= misses_next;
            m_data_reg.evict_total <= evicts_next;
        end
    end

    // Tag memory port: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_row_reg <= tag_mem[q_data[SET_W-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/set_assoc_lru_cache_tag_model.sv
// Top level of the set-associative LRU cache tag model. Each input transaction
// (opcode, address) yields exactly one result transaction with hit/miss/evict
// flags and saturating running totals. The back end takes one access at a
// time: it reads the set's row from the tag memory, then compares all ways,
// chooses the LRU victim and, once the result register is free, writes the
// row back through the single tag memory port. A two-entry queue lets the
// input side keep accepting while a result waits. After reset a clearing
// pass writes every row of the tag memory, during which no access is accepted.
// Configuration writes (index 0 set bits, 1 offset bits, 2 ways) are taken at
// any time but must only be issued while the block is idle.
// Depends on salc_pkg, salc_front, salc_queue and salc_back.
module set_assoc_lru_cache_tag_model
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  access_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output result_t                m_data
);

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int REQ_W  = 1 + WCNT_W + ADDR_WIDTH + SET_W;

    logic             clear_busy;
    logic             q_push, q_in_ready;
    logic [REQ_W-1:0] q_in_data;
    logic             q_out_valid, q_pop;
    logic [REQ_W-1:0] q_out_data;

    salc_front #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .clear_busy(clear_busy),
        .q_in_ready(q_in_ready),
        .q_push    (q_push),
        .q_in_data (q_in_data)
    );

    salc_queue #(
        .DATA_W(REQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_push),
        .in_ready (q_in_ready),
        .in_data  (q_in_data),
        .out_valid(q_out_valid),
        .out_ready(q_pop),
        .out_data (q_out_data)
    );

    salc_back #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_out_valid),
        .q_pop     (q_pop),
        .q_data    (q_out_data),
        .clear_busy(clear_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Nothing can be queued while the tag memory is being cleared.
    a_queue_empty_in_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !q_out_valid
    ) else $error("queue holds a transaction during the clearing pass");

    // No result can exist before the clearing pass has finished.
    a_no_result_in_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !m_valid
    ) else $error("result presented during the clearing pass");

    // Running totals never go down from one result to the next.
    a_totals_monotone: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!m_valid
            || (m_data.hit_total >= $past(m_data.hit_total)
                && m_data.miss_total >= $past(m_data.miss_total)
                && m_data.evict_total >= $past(m_data.evict_total)))
    ) else $error("running total decreased");

endmodule
